@@ src/tld_pkg.sv @@
// Shared constants and transaction types for the TIFF LZW decoder.
package tld_pkg;

  localparam int TABLE_ENTRIES  = 4096;
  localparam int MAX_CODE_WIDTH = 12;
  localparam int CODE_W         = MAX_CODE_WIDTH;
  localparam int ENTRY_W        = CODE_W + 1;
  localparam int TBL_AW         = $clog2(TABLE_ENTRIES);
  localparam int STACK_DEPTH    = 4096;
  localparam int STACK_AW       = $clog2(STACK_DEPTH);
  localparam int DEPTH_W        = STACK_AW + 1;
  localparam int CNT_W          = 24;
  localparam int BUF_W          = 19;
  localparam int BCNT_W         = 5;
  localparam int CWID_W         = 4;

  localparam logic [CODE_W-1:0]  BYTE_CODES = CODE_W'(256);
  localparam logic [CODE_W-1:0]  CODE_CLEAR = CODE_W'(256);
  localparam logic [CODE_W-1:0]  CODE_END   = CODE_W'(257);
  localparam logic [ENTRY_W-1:0] FIRST_FREE = ENTRY_W'(258);
  localparam logic [CWID_W-1:0]  MIN_WIDTH  = CWID_W'(9);
  localparam logic [CWID_W-1:0]  MAX_WIDTH  = CWID_W'(MAX_CODE_WIDTH);
  localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } tld_in_t;

  typedef struct packed {
    logic               push_accepted;
    logic               out_valid;
    logic [7:0]         out_byte;
    logic [DEPTH_W-1:0] pending_count;
    logic               stream_done;
    logic [CNT_W-1:0]   consumed_count;
  } tld_out_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
  } tld_code_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
  } tld_entry_t;

endpackage

@@ src/tld_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/tld_unpack.sv @@
// MSB-first bit unpacker that gathers compressed bytes into variable-width codes.
module tld_unpack
  import tld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic [7:0]        in_byte,
  input  logic [CWID_W-1:0] code_width,
  output tld_code_t         code_o
);

  logic [BUF_W-1:0]   buf_r, buf_nxt;
  logic [BCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BUF_W-1:0]   joined;
  logic [BUF_W-1:0]   shifted;
  logic [BUF_W-1:0]   low_mask;
  logic [BCNT_W-1:0]  total;
  logic [BCNT_W-1:0]  sh;
  logic [ENTRY_W-1:0] width_mask;

  always_comb begin
    joined     = {buf_r[BUF_W-9:0], in_byte};
    total      = cnt_r + BCNT_W'(8);
    sh         = total - BCNT_W'(code_width);
    shifted    = joined >> sh;
    low_mask   = (BUF_W'(1) << sh) - BUF_W'(1);
    width_mask = (ENTRY_W'(1) << code_width) - ENTRY_W'(1);
    code_o.vld  = total >= BCNT_W'(code_width);
    code_o.code = shifted[CODE_W-1:0] & width_mask[CODE_W-1:0];
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (shift_en) begin
      if (code_o.vld) begin
        buf_nxt = joined & low_mask;
        cnt_nxt = sh;
      end else begin
        buf_nxt = joined;
        cnt_nxt = total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
    end else begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/tiff_lzw_decoder_core.sv @@
// TIFF LZW decoder top level: code sequencer over the string table and output stack RAMs.
// A transaction either pushes one compressed byte or pulls one decoded byte, and every
// transaction returns exactly one result transaction. A pull reads the output stack RAM,
// then loads the output register. A push that completes no code goes straight to the response
// step. A push that completes a code walks the prefix chain in the string table RAM, one
// read and one stack write per cycle; a code that yields no string goes from decode straight
// to the response step. Pushes are refused while decoded bytes are pending or after the end
// code. Both RAMs are written before they are read, so the block needs no clearing pass after
// reset.
module tiff_lzw_decoder_core
  import tld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tld_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tld_out_t out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEC   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [CODE_W-1:0]  cur_r, cur_nxt;
  logic [7:0]         last_r, last_nxt;
  logic               kwk_r, kwk_nxt;
  logic [CODE_W-1:0]  prev_r, prev_nxt;
  logic [7:0]         prev_first_r, prev_first_nxt;
  logic               after_clear_r, after_clear_nxt;
  logic [CWID_W-1:0]  width_r, width_nxt;
  logic [ENTRY_W-1:0] next_r, next_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               finished_r, finished_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               acc_r, acc_nxt;
  logic               pop_r, pop_nxt;
  logic               out_valid_r, out_valid_nxt;
  tld_out_t           out_data_r, out_data_nxt;

  logic               in_acc;
  logic               shift_en;
  tld_code_t          code_i;
  logic               push_req;
  logic [7:0]         push_byte;
  logic               added;
  logic [ENTRY_W-1:0] next_inc;
  logic [ENTRY_W-1:0] last_idx;
  logic [ENTRY_W-1:0] grow_at;
  logic [DEPTH_W-1:0] depth_dec;

  logic               tbl_we;
  tld_entry_t         tbl_wdata;
  logic               tbl_re;
  logic [CODE_W-1:0]  tbl_rcode;
  tld_entry_t         tbl_q;
  logic               stk_we;
  logic               stk_re;
  logic [7:0]         stk_q;

  tld_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (shift_en),
    .in_byte    (in_data.in_byte),
    .code_width (width_r),
    .code_o     (code_i)
  );

  tld_ram #(
    .WIDTH ($bits(tld_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (next_r[TBL_AW-1:0]),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_rcode[TBL_AW-1:0]),
    .rdata (tbl_q)
  );

  tld_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[STACK_AW-1:0]),
    .wdata (push_byte),
    .re    (stk_re),
    .raddr (depth_dec[STACK_AW-1:0]),
    .rdata (stk_q)
  );

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    code_nxt        = code_r;
    cur_nxt         = cur_r;
    last_nxt        = last_r;
    kwk_nxt         = kwk_r;
    prev_nxt        = prev_r;
    prev_first_nxt  = prev_first_r;
    after_clear_nxt = after_clear_r;
    width_nxt       = width_r;
    next_nxt        = next_r;
    depth_nxt       = depth_r;
    finished_nxt    = finished_r;
    count_nxt       = count_r;
    acc_nxt         = acc_r;
    pop_nxt         = pop_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && out_stall;
    shift_en        = 1'b0;
    push_req        = 1'b0;
    push_byte       = 8'd0;
    tbl_we          = 1'b0;
    tbl_re          = 1'b0;
    tbl_rcode       = cur_r;
    stk_we          = 1'b0;
    stk_re          = 1'b0;
    depth_dec       = depth_r - DEPTH_W'(1);
    added           = next_r < ENTRY_W'(TABLE_ENTRIES);
    next_inc        = added ? next_r + ENTRY_W'(1) : next_r;
    last_idx        = next_inc - ENTRY_W'(1);
    grow_at         = (ENTRY_W'(1) << width_r) - ENTRY_W'(2);
    tbl_wdata.prefix = prev_r;
    tbl_wdata.suffix = kwk_r ? prev_first_r : last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          acc_nxt   = 1'b0;
          pop_nxt   = 1'b0;
          state_nxt = ST_RESP;
          if (in_data.command == CMD_PULL) begin
            if (depth_r != '0) begin
              stk_re    = 1'b1;
              depth_nxt = depth_dec;
              pop_nxt   = 1'b1;
            end
          end else if (depth_r == '0 && !finished_r) begin
            acc_nxt  = 1'b1;
            shift_en = 1'b1;
            if (count_r != CNT_MAX) begin
              count_nxt = count_r + CNT_W'(1);
            end
            if (code_i.vld) begin
              code_nxt  = code_i.code;
              state_nxt = ST_DEC;
            end
          end
        end
      end
      ST_DEC: begin
        state_nxt = ST_RESP;
        priority if (code_r == CODE_END) begin
          finished_nxt = 1'b1;
        end else if (code_r == CODE_CLEAR) begin
          next_nxt        = FIRST_FREE;
          width_nxt       = MIN_WIDTH;
          after_clear_nxt = 1'b1;
        end else if (after_clear_r) begin
          if (code_r < BYTE_CODES) begin
            push_req        = 1'b1;
            push_byte       = code_r[7:0];
            prev_nxt        = code_r;
            prev_first_nxt  = code_r[7:0];
            after_clear_nxt = 1'b0;
          end
        end else if (ENTRY_W'(code_r) < next_r) begin
          kwk_nxt   = 1'b0;
          cur_nxt   = code_r;
          state_nxt = ST_START;
        end else begin
          kwk_nxt   = 1'b1;
          push_req  = 1'b1;
          push_byte = prev_first_r;
          cur_nxt   = prev_r;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (cur_r < BYTE_CODES) begin
          push_req  = 1'b1;
          push_byte = cur_r[7:0];
          last_nxt  = cur_r[7:0];
          state_nxt = ST_ADD;
        end else begin
          tbl_re    = 1'b1;
          tbl_rcode = cur_r;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        push_req  = 1'b1;
        push_byte = tbl_q.suffix;
        cur_nxt   = tbl_q.prefix;
        if (tbl_q.prefix >= BYTE_CODES) begin
          tbl_re    = 1'b1;
          tbl_rcode = tbl_q.prefix;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_ADD: begin
        tbl_we   = added;
        next_nxt = next_inc;
        if (last_idx == grow_at && width_r < MAX_WIDTH) begin
          width_nxt = width_r + CWID_W'(1);
        end
        if (!kwk_r) begin
          prev_nxt       = code_r;
          prev_first_nxt = last_r;
        end else if (added) begin
          prev_nxt = next_r[CODE_W-1:0];
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_data_nxt.push_accepted  = acc_r;
        out_data_nxt.out_valid      = pop_r;
        out_data_nxt.out_byte       = pop_r ? stk_q : 8'd0;
        out_data_nxt.pending_count  = depth_r;
        out_data_nxt.stream_done    = finished_r;
        out_data_nxt.consumed_count = count_r;
        out_valid_nxt               = 1'b1;
        state_nxt                   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_req && !depth_r[DEPTH_W-1]) begin
      stk_we    = 1'b1;
      depth_nxt = depth_r + DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prev_r        <= '0;
      prev_first_r  <= '0;
      after_clear_r <= 1'b1;
      width_r       <= MIN_WIDTH;
      next_r        <= FIRST_FREE;
      depth_r       <= '0;
      finished_r    <= 1'b0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      prev_r        <= prev_nxt;
      prev_first_r  <= prev_first_nxt;
      after_clear_r <= after_clear_nxt;
      width_r       <= width_nxt;
      next_r        <= next_nxt;
      depth_r       <= depth_nxt;
      finished_r    <= finished_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    cur_r      <= cur_nxt;
    last_r     <= last_nxt;
    kwk_r      <= kwk_nxt;
    acc_r      <= acc_nxt;
    pop_r      <= pop_nxt;
    out_data_r <= out_data_nxt;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("output stack depth out of range");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    width_r >= MIN_WIDTH && width_r <= MAX_WIDTH)
    else $error("code width out of range");

  a_next_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_r >= FIRST_FREE && next_r <= ENTRY_W'(TABLE_ENTRIES))
    else $error("next table entry out of range");

  a_walk_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> cur_r >= BYTE_CODES)
    else $error("prefix walk on a literal code");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result loaded outside the response step");

endmodule
